// ===== design/fpms_pkg.sv =====
// ----------------------------------------------------------------------------
// fpms_pkg
// Shared types, widths and arithmetic helpers for the falling path sum block.
// ----------------------------------------------------------------------------
package fpms_pkg;

	localparam int CELL_W     = 16;
	localparam int SUM_W      = 22;
	localparam int COL_W      = 7;
	localparam int SIZE_W     = 7;
	localparam int RESET_SIZE = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef logic signed [CELL_W-1:0] cell_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] best_sum;
		logic [COL_W-1:0]        best_column;
	} result_t;

	function automatic sum_t widen_cell(input cell_t v);
		return {{(SUM_W-CELL_W){v[CELL_W-1]}}, v};
	endfunction

	function automatic sum_t add_sat(input cell_t v, input sum_t b);
		logic signed [SUM_W:0] s;
		s = {{(SUM_W+1-CELL_W){v[CELL_W-1]}}, v} + {b[SUM_W-1], b};
		if (s > $signed({SUM_MAX[SUM_W-1], SUM_MAX})) begin
			return SUM_MAX;
		end else if (s < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) begin
			return SUM_MIN;
		end else begin
			return s[SUM_W-1:0];
		end
	endfunction

endpackage

// ===== design/fpms_channels.sv =====
// ----------------------------------------------------------------------------
// fpms channels
// Valid/ready channels that carry cells in and results out.
// ----------------------------------------------------------------------------
interface fpms_cell_if;
	logic                             valid;
	logic                             ready;
	logic signed [fpms_pkg::CELL_W-1:0] cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink   (input valid, input cell_value, output ready);
endinterface

interface fpms_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [fpms_pkg::SUM_W-1:0] best_sum;
	logic [fpms_pkg::COL_W-1:0]        best_column;

	modport source (output valid, output best_sum, output best_column, input ready);
	modport sink   (input valid, input best_sum, input best_column, output ready);
endinterface

// ===== design/fpms_row_mem.sv =====
// ----------------------------------------------------------------------------
// fpms_row_mem
// One-row store of running best sums, one write and one registered read.
// ----------------------------------------------------------------------------
module fpms_row_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  fpms_pkg::sum_t      wr_data,
	input  logic [ADDR_W-1:0]   rd_addr,
	output fpms_pkg::sum_t      rd_data
);

	fpms_pkg::sum_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/fpms_out_fifo.sv =====
// ----------------------------------------------------------------------------
// fpms_out_fifo
// Small result queue that decouples the pipeline from the output channel.
// ----------------------------------------------------------------------------
module fpms_out_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  fpms_pkg::result_t                   push_data,
	output logic [fpms_pkg::FIFO_CNT_W-1:0]     count,
	fpms_result_if.source                       results
);

	fpms_pkg::result_t mem [fpms_pkg::FIFO_DEPTH];
	logic [fpms_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [fpms_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [fpms_pkg::FIFO_CNT_W-1:0] count_q;
	logic                            pop;

	assign pop                 = results.valid && results.ready;
	assign count               = count_q;
	assign results.valid       = count_q != '0;
	assign results.best_sum    = mem[rd_ptr_q].best_sum;
	assign results.best_column = mem[rd_ptr_q].best_column;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != fpms_pkg::FIFO_CNT_W'(fpms_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

endmodule

// ===== design/falling_path_max_sum_dp.sv =====
// ----------------------------------------------------------------------------
// falling_path_max_sum_dp
// Maximum falling path sum over a square board streamed in row-major order.
// ----------------------------------------------------------------------------
// The block accepts one cell per clock cycle, with no gap between rows or
// boards, as long as the result queue has room. Each cell reads one entry of
// the row memory and writes one back, and that single write port sets the
// rate of one cell per cycle. A cell passes through two pipeline stages, s1
// and s2, and the result of a board then goes into the output queue that
// offers it. Writing the board size restarts the board at its first row.
// ----------------------------------------------------------------------------
module falling_path_max_sum_dp #(
	parameter int MAX_SIZE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [fpms_pkg::SIZE_W-1:0]   cfg_data,
	fpms_cell_if.sink                     cells,
	fpms_result_if.source                 results
);

	localparam int IDX_W     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int INIT_SIZE = (fpms_pkg::RESET_SIZE < MAX_SIZE) ?
		fpms_pkg::RESET_SIZE : MAX_SIZE;
	localparam logic [IDX_W-1:0] INIT_LAST = IDX_W'(INIT_SIZE - 1);

	function automatic logic [IDX_W-1:0] last_index(input logic [fpms_pkg::SIZE_W-1:0] sz);
		int n;
		n = int'(sz);
		if (n == 0) begin
			n = 1;
		end
		if (n > MAX_SIZE) begin
			n = MAX_SIZE;
		end
		return IDX_W'(n - 1);
	endfunction

	logic [IDX_W-1:0] last_q;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] row_q;
	logic             accept;
	logic             at_last_col;
	logic             at_last_row;
	logic [IDX_W-1:0] rd_addr;

	logic             v_s1;
	fpms_pkg::cell_t  value_s1;
	logic [IDX_W-1:0] col_s1;
	logic             first_row_s1;
	logic             first_col_s1;
	logic             last_col_s1;
	logic             last_row_s1;
	logic             byp_s1;
	fpms_pkg::sum_t   byp_data_s1;

	fpms_pkg::sum_t   rd_data;
	fpms_pkg::sum_t   old_next;
	fpms_pkg::sum_t   best_prev;
	fpms_pkg::sum_t   fresh;
	fpms_pkg::sum_t   here_q;
	fpms_pkg::sum_t   left_q;

	logic             v_s2;
	fpms_pkg::sum_t   fresh_s2;
	logic [IDX_W-1:0] col_s2;
	logic             first_col_s2;
	logic             last_col_s2;
	logic             last_row_s2;

	fpms_pkg::sum_t   best_q;
	logic [IDX_W-1:0] best_col_q;
	logic             take;
	fpms_pkg::sum_t   new_best;
	logic [IDX_W-1:0] new_col;
	logic             push;
	fpms_pkg::result_t push_data;
	logic [fpms_pkg::FIFO_CNT_W-1:0] fifo_count;
	logic [fpms_pkg::FIFO_CNT_W:0]   pending;

	assign pending = {1'b0, fifo_count} + (fpms_pkg::FIFO_CNT_W+1)'(v_s1)
		+ (fpms_pkg::FIFO_CNT_W+1)'(v_s2);
	assign cells.ready = pending < (fpms_pkg::FIFO_CNT_W+1)'(fpms_pkg::FIFO_DEPTH);
	assign accept      = cells.valid && cells.ready;
	assign at_last_col = col_q == last_q;
	assign at_last_row = row_q == last_q;
	assign rd_addr     = at_last_col ? '0 : col_q + IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= INIT_LAST;
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_write) begin
			last_q <= last_index(cfg_data);
			col_q  <= '0;
			row_q  <= '0;
		end else if (accept) begin
			if (at_last_col) begin
				col_q <= '0;
				row_q <= at_last_row ? '0 : row_q + IDX_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

	fpms_row_mem #(
		.DEPTH  (MAX_SIZE),
		.ADDR_W (IDX_W)
	) u_row_mem (
		.clk     (clk),
		.wr_en   (v_s1),
		.wr_addr (col_s1),
		.wr_data (fresh),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		value_s1     <= cells.cell_value;
		col_s1       <= col_q;
		first_row_s1 <= row_q == '0;
		first_col_s1 <= col_q == '0;
		last_col_s1  <= at_last_col;
		last_row_s1  <= at_last_row;
		byp_s1       <= v_s1 && (col_s1 == rd_addr);
		byp_data_s1  <= fresh;
	end

	// The entry being read may be written back by the cell ahead in the same cycle.
	always_comb begin
		old_next  = byp_s1 ? byp_data_s1 : rd_data;
		best_prev = here_q;
		if (!first_col_s1 && left_q > best_prev) begin
			best_prev = left_q;
		end
		if (!last_col_s1 && old_next > best_prev) begin
			best_prev = old_next;
		end
		fresh = first_row_s1 ? fpms_pkg::widen_cell(value_s1)
			: fpms_pkg::add_sat(value_s1, best_prev);
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			left_q <= here_q;
			here_q <= old_next;
		end
		fresh_s2     <= fresh;
		col_s2       <= col_s1;
		first_col_s2 <= first_col_s1;
		last_col_s2  <= last_col_s1;
		last_row_s2  <= last_row_s1;
	end

	always_comb begin
		take     = first_col_s2 || (fresh_s2 > best_q);
		new_best = take ? fresh_s2 : best_q;
		new_col  = take ? col_s2 : best_col_q;
		push     = v_s2 && last_row_s2 && last_col_s2;
		push_data.best_sum    = new_best;
		push_data.best_column = fpms_pkg::COL_W'(new_col) + fpms_pkg::COL_W'(1);
	end

	always_ff @(posedge clk) begin
		if (v_s2 && last_row_s2) begin
			best_q     <= new_best;
			best_col_q <= new_col;
		end
	end

	fpms_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.count     (fifo_count),
		.results   (results)
	);

	a_position_in_board: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= last_q && row_q <= last_q)
		else $error("board position beyond board size");

	a_room_for_result: assert property (@(posedge clk) disable iff (!arst_n)
		cells.ready |-> fifo_count < fpms_pkg::FIFO_CNT_W'(fpms_pkg::FIFO_DEPTH))
		else $error("cell taken without room for its result");

	a_board_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && at_last_col && at_last_row |=> col_q == '0 && row_q == '0)
		else $error("board did not restart after its last cell");

endmodule

// ===== tb/falling_path_max_sum_dp_monitor.sv =====
// ----------------------------------------------------------------------------
// falling_path_max_sum_dp_monitor
// Watches the cell and result channels and the size register port. It keeps
// its own copy of the row of best sums and predicts the answer of each board
// from every accepted cell request. Each accepted result is compared with the
// oldest predicted answer, field by field.
// ----------------------------------------------------------------------------
module falling_path_max_sum_dp_monitor #(
	parameter int MAX_SIZE = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [fpms_pkg::SIZE_W-1:0] cfg_data,
	fpms_cell_if                        cells,
	fpms_result_if                      results,
	output int                          errors,
	output int                          pending
);
	import fpms_pkg::*;

	localparam int SUM_HI = (1 << (SUM_W - 1)) - 1;
	localparam int SUM_LO = -(1 << (SUM_W - 1));

	logic [SIZE_W-1:0] size_reg;
	sum_t              row_mem [MAX_SIZE];
	sum_t              left_prev;
	sum_t              lead_sum;
	int unsigned       lead_col;
	int unsigned       row_pos;
	int unsigned       col_pos;
	result_t           awaited_answers [$];

	function automatic int unsigned active_size();
		if (size_reg == 0) begin
			return 1;
		end
		if (size_reg > MAX_SIZE) begin
			return MAX_SIZE;
		end
		return int'(size_reg);
	endfunction

	function automatic int clip_sum(input int s);
		if (s > SUM_HI) begin
			return SUM_HI;
		end
		if (s < SUM_LO) begin
			return SUM_LO;
		end
		return s;
	endfunction

	function automatic void restart_board_pos();
		left_prev = '0;
		row_pos   = 0;
		col_pos   = 0;
		lead_sum  = '0;
		lead_col  = 0;
	endfunction

	task automatic absorb_cell(input cell_t v);
		int unsigned n;
		int unsigned j;
		int          best;
		int          fresh;
		sum_t        old_here;
		result_t     answer;
		n = active_size();
		if (row_pos >= n || col_pos >= n) begin
			restart_board_pos();
		end
		j = col_pos;
		old_here = row_mem[j];
		if (row_pos == 0) begin
			fresh = int'(v);
		end else begin
			best = int'(old_here);
			if (j > 0 && left_prev > best) begin
				best = int'(left_prev);
			end
			if (j + 1 < n && row_mem[j + 1] > best) begin
				best = int'(row_mem[j + 1]);
			end
			fresh = clip_sum(int'(v) + best);
		end
		left_prev = old_here;
		row_mem[j] = sum_t'(fresh);
		if (row_pos == n - 1 && (j == 0 || fresh > lead_sum)) begin
			lead_sum = sum_t'(fresh);
			lead_col = j;
		end
		if (j + 1 < n) begin
			col_pos = j + 1;
		end else begin
			col_pos = 0;
			left_prev = '0;
			if (row_pos + 1 < n) begin
				row_pos++;
			end else begin
				answer.best_sum    = lead_sum;
				answer.best_column = COL_W'(lead_col + 1);
				awaited_answers.push_back(answer);
				restart_board_pos();
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			size_reg = SIZE_W'(RESET_SIZE);
			foreach (row_mem[i]) begin
				row_mem[i] = '0;
			end
			restart_board_pos();
			awaited_answers.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_write) begin
				size_reg = cfg_data;
				restart_board_pos();
			end
			if (cells.valid && cells.ready) begin
				absorb_cell(cells.cell_value);
			end
			if (results.valid && results.ready) begin
				if (awaited_answers.size() == 0) begin
					errors++;
					$display("%0t: result with no answer due, best_sum %0d best_column %0d",
						$time, results.best_sum, results.best_column);
				end else begin
					want = awaited_answers.pop_front();
					if (results.best_sum !== want.best_sum) begin
						errors++;
						$display("%0t: best_sum expected %0d actual %0d",
							$time, want.best_sum, results.best_sum);
					end
					if (results.best_column !== want.best_column) begin
						errors++;
						$display("%0t: best_column expected %0d actual %0d",
							$time, want.best_column, results.best_column);
					end
				end
			end
			pending = awaited_answers.size();
		end
	end

endmodule

// ===== tb/falling_path_max_sum_dp_test.sv =====
// ----------------------------------------------------------------------------
// falling_path_max_sum_dp_test
// Drives boards of cells into the falling path sum block and gives the
// verdict. Directed boards cover the value extremes, ties, one-column and
// zero-size boards; random boards of random sizes follow under several mixes
// of sender idling and receiver stalls. A long receiver hold-off fills the
// block while requests keep coming.
// ----------------------------------------------------------------------------
module falling_path_max_sum_dp_test;
	import fpms_pkg::*;

	localparam int BOARD_MAX     = 64;
	localparam int RANDOM_ITEMS  = 1950;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 20000;
	localparam int TIMEOUT_UNITS = 20_000_000;

	localparam int    DIR_SIZES  [4]  = '{1, 0, 2, 3};
	localparam int    DIR_COUNTS [4]  = '{3, 2, 4, 9};
	localparam cell_t DIR_CELLS  [18] = '{
		16'h7FFF, 16'h8000, 16'h0000,
		16'hFFFF, 16'h0001,
		16'h0003, 16'h0003, 16'h0000, 16'h0000,
		16'h0001, 16'h0002, 16'h0003,
		16'h0003, 16'h0002, 16'h0001,
		16'hFFFB, 16'h0007, 16'hFFFB
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_write;
	logic [SIZE_W-1:0] cfg_data;
	int                idle_pct;
	int                stall_pct  = 0;
	int                hold_asked = 0;
	int                random_sent;
	int                errors;
	int                pending;

	fpms_cell_if   cell_ch ();
	fpms_result_if result_ch ();

	falling_path_max_sum_dp #(
		.MAX_SIZE(BOARD_MAX)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data),
		.cells    (cell_ch),
		.results  (result_ch)
	);

	falling_path_max_sum_dp_monitor #(
		.MAX_SIZE(BOARD_MAX)
	) u_monitor (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data),
		.cells    (cell_ch),
		.results  (result_ch),
		.errors   (errors),
		.pending  (pending)
	);

	always #5 clk = ~clk;

	initial begin
		#(TIMEOUT_UNITS);
		$display("falling_path_max_sum_dp_test: done, errors");
		$finish;
	end

	initial begin
		int holds_done;
		holds_done = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != holds_done) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic int board_cells(input int sz);
		int n;
		n = (sz == 0) ? 1 : ((sz > BOARD_MAX) ? BOARD_MAX : sz);
		return n * n;
	endfunction

	function automatic cell_t rand_cell();
		case ($urandom_range(9))
			0: begin
				return 16'h7FFF;
			end
			1: begin
				return 16'h8000;
			end
			2, 3, 4: begin
				return cell_t'(int'($urandom_range(6)) - 3);
			end
			default: begin
				return cell_t'($urandom);
			end
		endcase
	endfunction

	task automatic send_cell(input cell_t v);
		while ($urandom_range(99) < idle_pct) begin
			cell_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cell_ch.valid      <= 1'b1;
		cell_ch.cell_value <= v;
		@(posedge clk);
		while (!cell_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic settle_idle();
		cell_ch.valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] sz);
		cfg_write <= 1'b1;
		cfg_data  <= sz;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic random_segment();
		int sz;
		int r;
		int total;
		int k;
		r = $urandom_range(99);
		if (r < 5) begin
			sz = 0;
		end else if (r < 12) begin
			sz = 1;
		end else if (r < 88) begin
			sz = $urandom_range(2, 8);
		end else begin
			sz = $urandom_range(9, 16);
		end
		settle_idle();
		write_size(SIZE_W'(sz));
		total = $urandom_range(1, 3) * board_cells(sz);
		if ($urandom_range(3) == 0) begin
			total += $urandom_range(0, board_cells(sz) - 1);
		end
		for (k = 0; k < total; k++) begin
			send_cell(rand_cell());
		end
		random_sent += total;
	endtask

	initial begin
		int k;
		int pos;
		int idx;
		int ph;
		arst_n             = 1'b0;
		cfg_write          = 1'b0;
		cfg_data           = '0;
		cell_ch.valid      = 1'b0;
		cell_ch.cell_value = '0;
		idle_pct           = 0;
		random_sent        = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The first board runs at the size the block comes out of reset with.
		for (k = 0; k < board_cells(RESET_SIZE); k++) begin
			send_cell(rand_cell());
		end
		random_sent = board_cells(RESET_SIZE);

		pos = 0;
		for (idx = 0; idx < 4; idx++) begin
			settle_idle();
			write_size(SIZE_W'(DIR_SIZES[idx]));
			for (k = 0; k < DIR_COUNTS[idx]; k++) begin
				send_cell(DIR_CELLS[pos + k]);
			end
			pos += DIR_COUNTS[idx];
		end

		// Every request answers at once here, so the long hold-off backs the block up.
		settle_idle();
		write_size(SIZE_W'(1));
		hold_asked <= hold_asked + 1;
		for (k = 0; k < 40; k++) begin
			send_cell(rand_cell());
		end

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct = 84;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 84;
				end
				default: begin
					idle_pct = 11;
					stall_pct <= 11;
				end
			endcase
			while (random_sent < (ph + 1) * RANDOM_ITEMS / 4) begin
				random_segment();
			end
		end

		cell_ch.valid <= 1'b0;
		for (k = 0; k < DRAIN_CYCLES && pending != 0; k++) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending != 0) begin
			$display("%0t: %0d answers never arrived", $time, pending);
		end
		if (errors == 0 && pending == 0) begin
			$display("falling_path_max_sum_dp_test: done, clean");
		end else begin
			$display("falling_path_max_sum_dp_test: done, errors");
		end
		$finish;
	end

endmodule
